[rtl/url_percent_decoder_assert.svh]
// Assertion macros for the URL percent decoder checker.
// Needs clk and rst_n in the scope where the macros are used.
`ifndef URL_PERCENT_DECODER_ASSERT_SVH
`define URL_PERCENT_DECODER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define UPD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("upd checker: same-cycle property failed");

// Next-cycle implication, disabled during reset.
`define UPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("upd checker: next-cycle property failed");

`endif

[rtl/upd_pkg.sv]
// Shared types, character codes and helpers for the URL percent decoder.
// No dependencies.
package upd_pkg;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // One encoded byte per beat.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } item_t;

    // One decoded result per beat.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       out_last;
    } result_t;

    // Escape tracking in the front end.
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } phase_t;

    // Queue entry: up to two results produced by one input byte.
    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic       valid0;  // 0 for the empty end marker
        logic       two;     // byte1 follows byte0
        logic       last;    // string ends with this entry
    } cmd_t;

    function automatic logic is_hex(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    endfunction

    // Valid only for hex characters; letters sit at 0x41/0x61 upwards.
    function automatic logic [3:0] nibble(input logic [7:0] c);
        return c[6] ? (c[3:0] + 4'd9) : c[3:0];
    endfunction

endpackage

[rtl/upd_front.sv]
// Front end: accepts encoded bytes, tracks escapes, emits queue entries.
// Depends on upd_pkg.
module upd_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    input  upd_pkg::item_t  item,
    input  logic            q_ready,
    output logic            push,
    output upd_pkg::cmd_t   cmd
);

    upd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]      held_reg, held_next;

    logic       accept;
    logic [7:0] c;
    logic       last;
    logic       hex;
    logic       p_emit;
    logic       p_esc;
    logic [7:0] p_byte;
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       push_req;

    assign item_ready = q_ready;
    assign accept     = item_valid && q_ready;
    assign c          = item.in_byte;
    assign last       = item.in_last;
    assign hex        = upd_pkg::is_hex(c);

    // Byte decoded with no escape pending.
    assign p_esc  = (c == upd_pkg::CH_PCT);
    assign p_emit = !p_esc;
    assign p_byte = (c == upd_pkg::CH_PLUS) ? upd_pkg::CH_SPACE : c;

    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        if (accept)
        begin
            case (phase_reg)
                upd_pkg::PH_PCT:
                begin
                    if (hex)
                    begin
                        phase_next = upd_pkg::PH_DIGIT;
                        held_next  = c;
                    end
                    else
                    begin
                        phase_next = p_esc ? upd_pkg::PH_PCT : upd_pkg::PH_IDLE;
                    end
                end
                upd_pkg::PH_DIGIT:
                begin
                    if (hex)
                    begin
                        phase_next = upd_pkg::PH_IDLE;
                    end
                    else
                    begin
                        phase_next = p_esc ? upd_pkg::PH_PCT : upd_pkg::PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = p_esc ? upd_pkg::PH_PCT : upd_pkg::PH_IDLE;
                end
            endcase
            if (last)
            begin
                phase_next = upd_pkg::PH_IDLE;
                held_next  = 8'h00;
            end
        end
    end

    always_comb
    begin
        cnt = 2'd0;
        b0  = p_byte;
        b1  = p_byte;
        case (phase_reg)
            upd_pkg::PH_PCT:
            begin
                if (!hex)
                begin
                    cnt = {1'b0, p_emit};
                end
            end
            upd_pkg::PH_DIGIT:
            begin
                if (hex)
                begin
                    cnt = 2'd1;
                    b0  = {upd_pkg::nibble(held_reg), upd_pkg::nibble(c)};
                end
                else
                begin
                    cnt = p_emit ? 2'd2 : 2'd1;
                    b0  = held_reg;
                end
            end
            default:
            begin
                cnt = {1'b0, p_emit};
            end
        endcase
        // String ends after '%' and one digit: the digit goes out as is.
        if (last && (phase_reg == upd_pkg::PH_PCT) && hex)
        begin
            cnt = 2'd1;
            b0  = c;
        end
        cmd.byte0  = (cnt == 2'd0) ? 8'h00 : b0;
        cmd.byte1  = b1;
        cmd.valid0 = (cnt != 2'd0);
        cmd.two    = (cnt == 2'd2);
        cmd.last   = last;
        push_req   = (cnt != 2'd0) || last;
    end

    assign push = accept && push_req;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= upd_pkg::PH_IDLE;
            held_reg  <= 8'h00;
        end
        else
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

[rtl/upd_queue.sv]
// Register FIFO of decoded entries between front and back ends.
// Depends on upd_pkg.
module upd_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  upd_pkg::cmd_t  push_data,
    output logic           ready,
    input  logic           pop,
    output upd_pkg::cmd_t  pop_data,
    output logic           nonempty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    upd_pkg::cmd_t mem_reg [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign ready    = (count_reg != FULL_CNT);
    assign nonempty = (count_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/upd_back.sv]
// Back end: splits queue entries into result beats behind an output register.
// Depends on upd_pkg.
module upd_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  upd_pkg::cmd_t     q_data,
    output logic              pop,
    output logic              result_valid,
    input  logic              result_ready,
    output upd_pkg::result_t  result
);

    logic              valid_reg, valid_next;
    upd_pkg::result_t  res_reg, res_next;
    logic              sec_reg, sec_next;
    logic [7:0]        sec_byte_reg, sec_byte_next;
    logic              sec_last_reg, sec_last_next;
    logic              load;

    assign load = !valid_reg || result_ready;
    assign pop  = load && !sec_reg && q_valid;

    always_comb
    begin
        valid_next    = valid_reg;
        res_next      = res_reg;
        sec_next      = sec_reg;
        sec_byte_next = sec_byte_reg;
        sec_last_next = sec_last_reg;
        if (load)
        begin
            if (sec_reg)
            begin
                valid_next         = 1'b1;
                res_next.out_byte  = sec_byte_reg;
                res_next.out_valid = 1'b1;
                res_next.out_last  = sec_last_reg;
                sec_next           = 1'b0;
            end
            else if (q_valid)
            begin
                valid_next         = 1'b1;
                res_next.out_byte  = q_data.byte0;
                res_next.out_valid = q_data.valid0;
                res_next.out_last  = q_data.last && !q_data.two;
                sec_next           = q_data.two;
                sec_byte_next      = q_data.byte1;
                sec_last_next      = q_data.last;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sec_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            sec_reg   <= sec_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg      <= res_next;
        sec_byte_reg <= sec_byte_next;
        sec_last_reg <= sec_last_next;
    end

    assign result_valid = valid_reg;
    assign result       = res_reg;

endmodule

[rtl/url_percent_decoder.sv]
// Top level of the URL percent decoder: front end, entry queue, back end.
// Depends on upd_pkg, upd_front, upd_queue, upd_back.
//
//  channel  | valid        | ready        | payload               | beat
//  ---------+--------------+--------------+-----------------------+----------------------
//  item     | item_valid   | item_ready   | item   (upd_pkg::item_t)   | one encoded byte
//  result   | result_valid | result_ready | result (upd_pkg::result_t) | one decoded byte
//
//  Flow: one item beat per cycle while item_ready is high; an accepted byte reaches
//    the result port through the queue write, then the output register.
//  Output: one result beat per cycle while result_ready is high; an item yielding
//    two bytes (held digit plus next byte) takes two result beats, absorbed by the queue.
//  Stalls: item_ready falls only when the FIFO_DEPTH-entry queue is full.
//  Reset: rst_n clears escape state, queue pointers and output valid at once.
module url_percent_decoder
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  upd_pkg::item_t    item,
    output logic              result_valid,
    input  logic              result_ready,
    output upd_pkg::result_t  result
);

    // Front end to queue.
    logic           push;
    upd_pkg::cmd_t  push_cmd;
    logic           q_ready;

    // Queue to back end.
    logic           pop;
    upd_pkg::cmd_t  pop_cmd;
    logic           q_nonempty;

    // Escape tracking and classification; one queue entry per producing byte or string end.
    upd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .q_ready    (q_ready),
        .push       (push),
        .cmd        (push_cmd)
    );

    // Decouples the one-beat-in side from the up-to-two-beats-out side.
    upd_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .ready     (q_ready),
        .pop       (pop),
        .pop_data  (pop_cmd),
        .nonempty  (q_nonempty)
    );

    // Result serialiser with registered output.
    upd_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_nonempty),
        .q_data       (pop_cmd),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

[rtl/upd_checker.sv]
// Port-level checker for the URL percent decoder, bound to the top level.
// Depends on upd_pkg and url_percent_decoder_assert.svh.
`include "url_percent_decoder_assert.svh"

module upd_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_ready,
    input upd_pkg::item_t    item,
    input logic              result_valid,
    input logic              result_ready,
    input upd_pkg::result_t  result
);

    // Strings whose final byte is in but whose last result is not yet out.
    logic [7:0] pend_reg, pend_next;
    logic       in_end;
    logic       out_end;

    assign in_end  = item_valid && item_ready && item.in_last;
    assign out_end = result_valid && result_ready && result.out_last;

    always_comb
    begin
        pend_next = pend_reg;
        if (in_end && !out_end)
        begin
            pend_next = pend_reg + 8'd1;
        end
        else if (out_end && !in_end)
        begin
            pend_next = pend_reg - 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 8'd0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `UPD_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result))
    `UPD_ASSERT_NOW(a_marker_form, result_valid && !result.out_valid, result.out_last && (result.out_byte == 8'h00))
    `UPD_ASSERT_NOW(a_last_has_source, result_valid && result.out_last, pend_reg != 8'd0)

endmodule

bind url_percent_decoder upd_checker u_upd_checker (.*);
